[src/mmdmbc1_pkg.sv]
// Shared constants for the memory map decoder with MBC1 banking.
// Holds region codes, configuration register indexes and address boundaries.
// No dependencies.
package mmdmbc1_pkg;

	// Bus access kinds carried by the op field.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Region codes reported on the result channel.
	localparam logic [3:0] REGION_BOOT     = 4'd0;
	localparam logic [3:0] REGION_ROM      = 4'd1;
	localparam logic [3:0] REGION_VRAM     = 4'd2;
	localparam logic [3:0] REGION_EXTRAM   = 4'd3;
	localparam logic [3:0] REGION_WRAM     = 4'd4;
	localparam logic [3:0] REGION_OAM      = 4'd5;
	localparam logic [3:0] REGION_UNUSABLE = 4'd6;
	localparam logic [3:0] REGION_IO       = 4'd7;
	localparam logic [3:0] REGION_HRAM     = 4'd8;
	localparam logic [3:0] REGION_IE       = 4'd9;

	// Configuration register indexes.
	localparam logic [2:0] CFG_MBC1_ENABLE    = 3'd0;
	localparam logic [2:0] CFG_ROM_BANK_COUNT = 3'd1;
	localparam logic [2:0] CFG_VRAM_BANK      = 3'd2;
	localparam logic [2:0] CFG_WRAM_BANK      = 3'd3;
	localparam logic [2:0] CFG_BOOT_ROM_KIND  = 3'd4;

	// Boot ROM kinds.
	localparam logic [1:0] BOOT_NONE = 2'd0;
	localparam logic [1:0] BOOT_EXT  = 2'd2;

	// Address boundaries.
	localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
	localparam logic [15:0] ADDR_BOOT2_LO  = 16'h0200;
	localparam logic [15:0] ADDR_BOOT2_END = 16'h0900;
	localparam logic [15:0] ADDR_VRAM      = 16'h8000;
	localparam logic [15:0] ADDR_EXTRAM    = 16'hA000;
	localparam logic [15:0] ADDR_WRAM0     = 16'hC000;
	localparam logic [15:0] ADDR_WRAM1     = 16'hD000;
	localparam logic [15:0] ADDR_ECHO      = 16'hE000;
	localparam logic [15:0] ADDR_OAM       = 16'hFE00;
	localparam logic [15:0] ADDR_UNUSABLE  = 16'hFEA0;
	localparam logic [15:0] ADDR_IO        = 16'hFF00;
	localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
	localparam logic [15:0] ADDR_IE        = 16'hFFFF;
	localparam logic [15:0] ADDR_BOOT_OFF  = 16'hFF50;
	localparam logic [15:0] ECHO_FOLD      = 16'hE000 - 16'hC000;

	// MBC1 register windows, selected by address bits 14:13 below 0x8000.
	localparam logic [1:0] MBC_WIN_LOW  = 2'b01;
	localparam logic [1:0] MBC_WIN_HIGH = 2'b10;
	localparam logic [1:0] MBC_WIN_MODE = 2'b11;

	localparam logic [4:0] BANK_LOW_MASK = 5'h1F;

	// The raw ROM bank number is bank_high (2 bits) over bank_low (5 bits).
	localparam int BANK_W = 7;

	localparam int MAX_ROM_BANKS_DEF = 128;

	localparam int OFFSET_W = 21;

endpackage

[src/memory_map_decoder_with_mbc1_unit.sv]
// Top level of the memory map decoder with MBC1 cartridge banking.
// Depends on mmdmbc1_pkg for region codes, register indexes and address bounds.
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  -----------------------------
// input     in         in_valid / in_stall    op, address, write_data
// result    out        out_valid / out_stall  region, offset, store
// config    in         cfg_we (no handshake)  cfg_index, cfg_data
//
// A transaction that hits ROM (below 0x8000, boot overlay aside) passes through acceptance,
// the bit-serial remainder unit that reduces the bank number modulo the bank count, and
// the load of the result register before the next transaction can be accepted. Every
// other transaction skips the remainder unit and goes from acceptance to the result load.
// A single compare-and-subtract unit serves the remainder loop.
// Reset (arst_n low) clears the sequencer, the result valid flag, the MBC1 bank
// registers and the configuration registers to their documented values.
// in_stall is high while a transaction is being decoded; a stalled result waits in the
// output register while the next transaction can already be accepted.
module memory_map_decoder_with_mbc1_unit
	import mmdmbc1_pkg::*;
#(
	parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port.
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	// Input channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	// Result channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          region,
	output logic [OFFSET_W-1:0] offset,
	output logic                store
);

	// Width of the effective bank count (it can equal MAX_ROM_BANKS itself) and of a
	// reduced bank number (always below MAX_ROM_BANKS).
	localparam int NW = $clog2(MAX_ROM_BANKS + 1);
	localparam int BW = $clog2(MAX_ROM_BANKS);
	localparam logic [7:0] MAX_CNT = 8'(MAX_ROM_BANKS);
	localparam logic [2:0] DIV_LAST = 3'(BANK_W - 1);

	// Sequencer states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;

	// Configuration registers.
	logic       mbc1_enable_q;
	logic [7:0] rom_bank_count_q;
	logic       vram_bank_q;
	logic [2:0] wram_bank_q;
	logic [1:0] boot_rom_kind_q;

	// MBC1 and boot overlay state.
	logic [4:0] bank_low_q;
	logic [1:0] bank_high_q;
	logic       bank_mode_q;
	logic       overlay_q;

	// Captured transaction.
	logic        op_q;
	logic [15:0] addr_q;

	// Remainder unit.
	logic [BANK_W-1:0] dvd_q;
	logic [NW-1:0]     rem_q;
	logic [2:0]        cnt_q;

	// Result register.
	logic                out_valid_q;
	logic [3:0]          region_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                store_q;

	logic accept;
	logic mbc_write;
	logic [4:0] bank_low_d;
	logic [1:0] bank_high_d;
	logic       bank_mode_d;
	logic [BANK_W-1:0] bank_raw;
	logic rom_hit;
	logic boot_hit;
	logic [NW-1:0] n_eff;
	logic [NW:0]   trial;
	logic [NW:0]   trial_sub;
	logic [NW-1:0] rem_next;
	logic [15:0] fa;
	logic [3:0]          region_d;
	logic [OFFSET_W-1:0] offset_d;
	logic out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// A cartridge write updates the MBC1 registers at acceptance; the bank that the
	// remainder unit reduces is taken from the values in force after that update.
	assign mbc_write = (op == OP_WRITE) && (address < ADDR_VRAM) && mbc1_enable_q;

	always_comb begin
		bank_low_d  = bank_low_q;
		bank_high_d = bank_high_q;
		bank_mode_d = bank_mode_q;
		if (mbc_write) begin
			unique case (address[14:13])
				MBC_WIN_LOW: begin
					bank_low_d = ((write_data[4:0] & BANK_LOW_MASK) == 5'd0)
						? 5'd1 : (write_data[4:0] & BANK_LOW_MASK);
				end
				MBC_WIN_HIGH: bank_high_d = write_data[1:0];
				MBC_WIN_MODE: bank_mode_d = write_data[0];
				default: ;
			endcase
		end
	end

	// The lower ROM window sees bank 0, or bank_high << 5 in banking mode 1 with MBC1 enabled.
	// The upper window sees the full switchable bank.
	always_comb begin
		if (address[14]) begin
			bank_raw = {bank_high_d, bank_low_d};
		end else if (mbc1_enable_q && bank_mode_d) begin
			bank_raw = {bank_high_d, 5'd0};
		end else begin
			bank_raw = '0;
		end
	end

	// Boot overlay applies to reads while the overlay is up and a boot ROM exists.
	assign boot_hit = (op == OP_READ) && overlay_q && (boot_rom_kind_q != BOOT_NONE) &&
		((address < ADDR_BOOT_END) ||
		 ((boot_rom_kind_q >= BOOT_EXT) && (address >= ADDR_BOOT2_LO) &&
		  (address < ADDR_BOOT2_END)));
	assign rom_hit = (address < ADDR_VRAM) && !boot_hit;

	// A bank count of zero behaves as one, and counts above the maximum are clamped.
	always_comb begin
		if (rom_bank_count_q == 8'd0) begin
			n_eff = NW'(1);
		end else if (rom_bank_count_q > MAX_CNT) begin
			n_eff = NW'(MAX_ROM_BANKS);
		end else begin
			n_eff = rom_bank_count_q[NW-1:0];
		end
	end

	// One restoring step of the remainder: bring in the next dividend bit, and take
	// the count away once when the partial remainder reaches it.
	assign trial     = {rem_q, dvd_q[BANK_W-1]};
	assign trial_sub = trial - {1'b0, n_eff};
	assign rem_next  = (trial >= {1'b0, n_eff}) ? trial_sub[NW-1:0] : trial[NW-1:0];

	// The echo area folds onto work RAM before decoding.
	assign fa = ((addr_q >= ADDR_ECHO) && (addr_q < ADDR_OAM)) ? (addr_q - ECHO_FOLD) : addr_q;

	always_comb begin
		if (state_q == S_FIN && op_q == OP_READ && overlay_q &&
			boot_rom_kind_q != BOOT_NONE &&
			((addr_q < ADDR_BOOT_END) ||
			 ((boot_rom_kind_q >= BOOT_EXT) && (addr_q >= ADDR_BOOT2_LO) &&
			  (addr_q < ADDR_BOOT2_END)))) begin
			region_d = REGION_BOOT;
			offset_d = OFFSET_W'(addr_q);
		end else if (fa < ADDR_VRAM) begin
			// Both ROM windows place the reduced bank above a 16 KiB offset.
			region_d = REGION_ROM;
			offset_d = OFFSET_W'({rem_q[BW-1:0], fa[13:0]});
		end else if (fa < ADDR_EXTRAM) begin
			region_d = REGION_VRAM;
			offset_d = OFFSET_W'({vram_bank_q, fa[12:0]});
		end else if (fa < ADDR_WRAM0) begin
			region_d = REGION_EXTRAM;
			offset_d = OFFSET_W'(fa[12:0]);
		end else if (fa < ADDR_WRAM1) begin
			region_d = REGION_WRAM;
			offset_d = OFFSET_W'(fa[11:0]);
		end else if (fa < ADDR_ECHO) begin
			region_d = REGION_WRAM;
			offset_d = OFFSET_W'({wram_bank_q, fa[11:0]});
		end else if (fa < ADDR_UNUSABLE) begin
			region_d = REGION_OAM;
			offset_d = OFFSET_W'(fa[7:0]);
		end else if (fa < ADDR_IO) begin
			region_d = REGION_UNUSABLE;
			offset_d = '0;
		end else if (fa < ADDR_HRAM) begin
			region_d = REGION_IO;
			offset_d = OFFSET_W'(fa[6:0]);
		end else if (fa < ADDR_IE) begin
			region_d = REGION_HRAM;
			offset_d = OFFSET_W'(fa[6:0]);
		end else begin
			region_d = REGION_IE;
			offset_d = '0;
		end
	end

	// Configuration registers. Indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbc1_enable_q    <= 1'b0;
			rom_bank_count_q <= 8'd2;
			vram_bank_q      <= 1'b0;
			wram_bank_q      <= 3'd1;
			boot_rom_kind_q  <= BOOT_NONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MBC1_ENABLE:    mbc1_enable_q    <= cfg_data[0];
				CFG_ROM_BANK_COUNT: rom_bank_count_q <= cfg_data;
				CFG_VRAM_BANK:      vram_bank_q      <= cfg_data[0];
				CFG_WRAM_BANK:      wram_bank_q      <= cfg_data[2:0];
				CFG_BOOT_ROM_KIND:  boot_rom_kind_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// MBC1 registers and the boot overlay flag change only when a transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_low_q  <= 5'd1;
			bank_high_q <= 2'd0;
			bank_mode_q <= 1'b0;
			overlay_q   <= 1'b1;
		end else if (accept) begin
			bank_low_q  <= bank_low_d;
			bank_high_q <= bank_high_d;
			bank_mode_q <= bank_mode_d;
			if ((op == OP_WRITE) && (address == ADDR_BOOT_OFF) && (write_data != 8'd0)) begin
				overlay_q <= 1'b0;
			end
		end
	end

	// Sequencer and remainder unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= rom_hit ? S_DIV : S_FIN;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= S_FIN;
					end
					cnt_q <= cnt_q + 3'd1;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			addr_q <= address;
			dvd_q  <= bank_raw;
			rem_q  <= '0;
		end else if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[BANK_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	// Result register: loaded when the decode finishes and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			region_q <= region_d;
			offset_q <= offset_d;
			store_q  <= (op_q == OP_WRITE) && (addr_q >= ADDR_VRAM);
		end
	end

	assign out_valid = out_valid_q;
	assign region    = region_q;
	assign offset    = offset_q;
	assign store     = store_q;

endmodule
